// ----- rtl/core/smct_pkg.sv -----
`default_nettype none
// ============================================================================
// smct_pkg
// Shared types and codes for the station match count table.
// ============================================================================
package smct_pkg;

    localparam int unsigned MAX_STATIONS_DEF = 64;

    localparam int unsigned REQ_W    = 2;
    localparam int unsigned CHAN_W   = 7;
    localparam int unsigned ID_W     = 40;
    localparam int unsigned LVL_W    = 8;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned PKT_W    = 32;
    localparam int unsigned ECNT_W   = 7;

    localparam logic [REQ_W-1:0] REQ_REPORT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DROPPED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CHAN_W-1:0] channel;
        logic [ID_W-1:0]   station_id;
        logic              from_fixed_part;
        logic [LVL_W-1:0]  signal_level;
        logic [IDX_W-1:0]  entry_index;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                entry_valid;
        logic [CHAN_W-1:0]   out_channel;
        logic [ID_W-1:0]     out_station_id;
        logic [LVL_W-1:0]    out_signal_level;
        logic [PKT_W-1:0]    fixed_count;
        logic [PKT_W-1:0]    portable_count;
        logic [ECNT_W-1:0]   entry_count;
    } t_res;

    // token passed from cell to cell during a lookup pass
    typedef struct packed {
        logic              valid;
        logic              hit;
        logic              found;
        logic [CHAN_W-1:0] chan;
        logic [ID_W-1:0]   id;
        logic [LVL_W-1:0]  lvl;
        logic [PKT_W-1:0]  fix_cnt;
        logic [PKT_W-1:0]  por_cnt;
    } t_link;

endpackage
`default_nettype wire

// ----- rtl/core/station_match_count_table_top.sv -----
`default_nettype none
// ============================================================================
// station_match_count_table_top
// Station table keyed by channel and station identity, with saturating
// packet counters per entry, built as a chain of one cell per entry.
// ============================================================================
// Each transaction walks a token down a chain of MAX_STATIONS cells, each
// cell registering it on to the next, and busy stays high until the result
// strobe; busy drops with the strobe and a new transaction is accepted only
// once busy is low, so the chain length sets the time per transaction.
// The result strobe is high for exactly one cycle and the result must be
// taken then.
module station_match_count_table_top #(
    parameter int unsigned MAX_STATIONS = smct_pkg::MAX_STATIONS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire smct_pkg::t_req i_req,
    output logic                o_strobe,
    output smct_pkg::t_res      o_res
);
    import smct_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_STATIONS + 1);

    logic             r_busy;
    logic             r_go;
    t_req             r_req;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_strobe;
    t_res             r_res;
    t_res             n_res;
    t_link            w_link [0:MAX_STATIONS];
    t_link            w_tail;
    logic             accept;

    assign accept = start && !r_busy;

    always_comb begin
        w_link[0]       = '0;
        w_link[0].valid = r_go;
    end

    for (genvar g = 0; g < MAX_STATIONS; g++) begin : g_cell
        smct_cell #(
            .MAX_STATIONS (MAX_STATIONS),
            .IDX          (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (r_req),
            .i_count (r_count),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1])
        );
    end

    assign w_tail = w_link[MAX_STATIONS];

    // result of a finished pass
    always_comb begin
        n_res   = '0;
        n_count = r_count;
        unique case (r_req.req_type)
            REQ_REPORT: begin
                if (w_tail.hit) begin
                    n_res.status = ST_UPDATED;
                end else if (r_count < CNT_W'(MAX_STATIONS)) begin
                    n_res.status = ST_INSERTED;
                    n_count      = r_count + 1'b1;
                end else begin
                    n_res.status = ST_DROPPED;
                end
            end
            REQ_CLEAR: begin
                n_res.status = ST_CLEARED;
                n_count      = '0;
            end
            default: begin
                if (w_tail.found) begin
                    n_res.status           = ST_READ_OK;
                    n_res.entry_valid      = 1'b1;
                    n_res.out_channel      = w_tail.chan;
                    n_res.out_station_id   = w_tail.id;
                    n_res.out_signal_level = w_tail.lvl;
                    n_res.fixed_count      = w_tail.fix_cnt;
                    n_res.portable_count   = w_tail.por_cnt;
                end else begin
                    n_res.status = ST_RANGE;
                end
            end
        endcase
        n_res.entry_count = ECNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_go     <= 1'b0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_go     <= accept;
            r_strobe <= w_tail.valid;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (w_tail.valid) begin
                r_busy <= 1'b0;
            end
            if (w_tail.valid) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
        if (w_tail.valid) begin
            r_res <= n_res;
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule
`default_nettype wire

// ----- rtl/core/smct_cell.sv -----
`default_nettype none
// ============================================================================
// smct_cell
// One table entry: match, update, insert and read for its own slot, with
// the lookup token registered on to the next cell.
// ============================================================================
module smct_cell #(
    parameter int unsigned MAX_STATIONS = smct_pkg::MAX_STATIONS_DEF,
    parameter int unsigned IDX          = 0,
    localparam int unsigned CNT_W       = $clog2(MAX_STATIONS + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire smct_pkg::t_req   i_req,
    input  wire logic [CNT_W-1:0] i_count,
    input  wire smct_pkg::t_link  i_link,
    output smct_pkg::t_link       o_link
);
    import smct_pkg::*;

    localparam int unsigned CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic [PKT_W-1:0] PKT_TOP = '1;

    logic [CHAN_W-1:0] r_chan;
    logic [ID_W-1:0]   r_id;
    logic [LVL_W-1:0]  r_lvl;
    logic [PKT_W-1:0]  r_fix;
    logic [PKT_W-1:0]  r_por;
    logic              r_link_vld;
    t_link             r_link;
    t_link             n_link;

    logic in_use;
    logic is_report;
    logic is_read;
    logic hit_here;
    logic ins_here;
    logic rd_here;

    always_comb begin
        in_use    = (CNT_W'(IDX) < i_count);
        is_report = (i_req.req_type == REQ_REPORT);
        is_read   = (i_req.req_type != REQ_REPORT) && (i_req.req_type != REQ_CLEAR);
        hit_here  = i_link.valid && is_report && in_use &&
                    (r_chan == i_req.channel) && (r_id == i_req.station_id);
        ins_here  = i_link.valid && is_report && !i_link.hit &&
                    (i_count == CNT_W'(IDX));
        rd_here   = i_link.valid && is_read && in_use &&
                    (CMP_W'(i_req.entry_index) == CMP_W'(IDX));
        n_link = i_link;
        n_link.hit = i_link.hit | hit_here;
        if (rd_here) begin
            n_link.found   = 1'b1;
            n_link.chan    = r_chan;
            n_link.id      = r_id;
            n_link.lvl     = r_lvl;
            n_link.fix_cnt = r_fix;
            n_link.por_cnt = r_por;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (ins_here) begin
            r_chan <= i_req.channel;
            r_id   <= i_req.station_id;
            r_lvl  <= i_req.signal_level;
            r_fix  <= '0;
            r_por  <= '0;
        end else if (hit_here) begin
            r_lvl <= i_req.signal_level;
            if (i_req.from_fixed_part) begin
                if (r_fix != PKT_TOP) begin
                    r_fix <= r_fix + 1'b1;
                end
            end else begin
                if (r_por != PKT_TOP) begin
                    r_por <= r_por + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_vld <= 1'b0;
        end else begin
            r_link_vld <= n_link.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link <= n_link;
    end

    always_comb begin
        o_link       = r_link;
        o_link.valid = r_link_vld;
    end

endmodule
`default_nettype wire

// ----- rtl/core/smct_chk.sv -----
`default_nettype none
// ============================================================================
// smct_chk
// Port-level checks for the station match count table.
// ============================================================================
module smct_chk #(
    parameter int unsigned MAX_STATIONS = smct_pkg::MAX_STATIONS_DEF
) (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire smct_pkg::t_req i_req,
    input wire logic           o_strobe,
    input wire smct_pkg::t_res o_res
);
    import smct_pkg::*;

    logic unused_req;
    assign unused_req = ^i_req;

    // one result per transaction, never back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe on two consecutive cycles");

    // a result ends the busy period
    a_strobe_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (!busy && $past(busy)))
        else $error("result strobe without a finished transaction");

    // an accepted transaction makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // entry data only with a successful read
    a_valid_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_res.entry_valid == (o_res.status == ST_READ_OK)))
        else $error("entry_valid disagrees with status");

    // entry count never exceeds the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (32'(o_res.entry_count) <= 32'(MAX_STATIONS)))
        else $error("entry count beyond table size");

endmodule

bind station_match_count_table_top smct_chk #(
    .MAX_STATIONS (MAX_STATIONS)
) u_smct_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives station reports, reads and clears into the station match count
// table. Every transaction is predicted by a software copy of the table:
// match on channel and identity, saturating per-part counters, append on a
// miss, drop when full. Each result strobe is compared field by field with
// the oldest expected result. A short directed table comes first, then random
// episodes that fill, hit, overflow and clear the table.
// ============================================================================
module testbench;
    import smct_pkg::*;

    localparam int unsigned SLOTS       = MAX_STATIONS_DEF;
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned POOL_SIZE   = 8;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned DRAIN_WAIT  = 100;

    typedef struct {
        t_req req;
        bit   given;
        t_res res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_strobe;
    t_res o_res;

    station_match_count_table_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // software copy of the station table
    logic [CHAN_W-1:0] tbl_chan [SLOTS];
    logic [ID_W-1:0]   tbl_id   [SLOTS];
    logic [LVL_W-1:0]  tbl_lvl  [SLOTS];
    logic [PKT_W-1:0]  tbl_fix  [SLOTS];
    logic [PKT_W-1:0]  tbl_por  [SLOTS];
    int unsigned       tbl_used;

    logic [CHAN_W-1:0] pool_chan [POOL_SIZE];
    logic [ID_W-1:0]   pool_id   [POOL_SIZE];

    t_res        pending_results [$];
    t_row        directed_rows [$];
    int unsigned errors;
    int unsigned cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_res station_table_apply(t_req r);
        t_res res;
        int   hit;
        res = '0;
        hit = -1;
        case (r.req_type)
            REQ_REPORT: begin
                for (int i = 0; i < int'(tbl_used); i++) begin
                    if (hit < 0 && tbl_chan[i] == r.channel && tbl_id[i] == r.station_id)
                        hit = i;
                end
                if (hit >= 0) begin
                    if (r.from_fixed_part) begin
                        if (tbl_fix[hit] != '1) tbl_fix[hit] = tbl_fix[hit] + 1'b1;
                    end else begin
                        if (tbl_por[hit] != '1) tbl_por[hit] = tbl_por[hit] + 1'b1;
                    end
                    tbl_lvl[hit] = r.signal_level;
                    res.status = ST_UPDATED;
                end else if (tbl_used >= SLOTS) begin
                    res.status = ST_DROPPED;
                end else begin
                    tbl_chan[tbl_used] = r.channel;
                    tbl_id[tbl_used]   = r.station_id;
                    tbl_lvl[tbl_used]  = r.signal_level;
                    tbl_fix[tbl_used]  = '0;
                    tbl_por[tbl_used]  = '0;
                    tbl_used++;
                    res.status = ST_INSERTED;
                end
            end
            REQ_CLEAR: begin
                tbl_used = 0;
                res.status = ST_CLEARED;
            end
            default: begin
                if (r.entry_index < tbl_used) begin
                    res.status           = ST_READ_OK;
                    res.entry_valid      = 1'b1;
                    res.out_channel      = tbl_chan[r.entry_index];
                    res.out_station_id   = tbl_id[r.entry_index];
                    res.out_signal_level = tbl_lvl[r.entry_index];
                    res.fixed_count      = tbl_fix[r.entry_index];
                    res.portable_count   = tbl_por[r.entry_index];
                end else begin
                    res.status = ST_RANGE;
                end
            end
        endcase
        res.entry_count = tbl_used[ECNT_W-1:0];
        return res;
    endfunction

    function automatic t_req mk_req(logic [REQ_W-1:0] kind, logic [CHAN_W-1:0] ch,
                                    logic [ID_W-1:0] id, logic fixed,
                                    logic [LVL_W-1:0] lvl, logic [IDX_W-1:0] idx);
        t_req r;
        r.req_type        = kind;
        r.channel         = ch;
        r.station_id      = id;
        r.from_fixed_part = fixed;
        r.signal_level    = lvl;
        r.entry_index     = idx;
        return r;
    endfunction

    function automatic t_res mk_res(logic [STATUS_W-1:0] st, logic [ECNT_W-1:0] cnt);
        t_res r;
        r = '0;
        r.status      = st;
        r.entry_count = cnt;
        return r;
    endfunction

    function automatic void add_row(t_req r, bit given, t_res res);
        t_row row;
        row.req   = r;
        row.given = given;
        row.res   = res;
        directed_rows.push_back(row);
    endfunction

    function automatic t_req rand_req();
        t_req        r;
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        r.req_type        = REQ_W'($urandom_range(0, 3));
        r.channel         = CHAN_W'($urandom);
        r.station_id      = wide[ID_W-1:0];
        r.from_fixed_part = 1'($urandom);
        r.signal_level    = LVL_W'($urandom);
        r.entry_index     = IDX_W'($urandom);
        return r;
    endfunction

    // pool keys give hits; fresh keys share a pool key's channel or id, flip one id bit of one, or are random
    function automatic t_req make_report(bit fresh);
        t_req        r;
        int unsigned k;
        r = rand_req();
        r.req_type = REQ_REPORT;
        k = $urandom_range(0, POOL_SIZE - 1);
        if (!fresh) begin
            r.channel    = pool_chan[k];
            r.station_id = pool_id[k];
        end else begin
            case ($urandom_range(0, 3))
                0: r.channel = pool_chan[k];
                1: r.station_id = pool_id[k];
                2: begin
                    r.channel    = pool_chan[k];
                    r.station_id = pool_id[k] ^ (ID_W'(1) << $urandom_range(0, ID_W - 1));
                end
                default: ;
            endcase
            if ($urandom_range(0, 3) == 0) begin
                pool_chan[k] = r.channel;
                pool_id[k]   = r.station_id;
            end
        end
        return r;
    endfunction

    function automatic t_req make_read();
        t_req r;
        r = rand_req();
        r.req_type = ($urandom_range(0, 3) == 0) ? REQ_SPARE : REQ_READ;
        if ($urandom_range(0, 1) == 0)
            r.entry_index = IDX_W'($urandom_range(0, (tbl_used < SLOTS) ? tbl_used : SLOTS - 1));
        return r;
    endfunction

    task automatic idle_gap(int unsigned n);
        @(negedge i_clk);
        start <= 1'b0;
        i_req <= rand_req();
        repeat (n - 1) begin
            @(negedge i_clk);
            i_req <= rand_req();
        end
    endtask

    task automatic send_item(t_req r, bit given, t_res res);
        t_res predicted;
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy !== 1'b0);
        predicted = station_table_apply(r);
        pending_results.push_back(given ? res : predicted);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected transaction expected none actual %0h", $time, o_res);
                errors++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_res.status);
                check_field("entry_valid", want.entry_valid, o_res.entry_valid);
                check_field("out_channel", want.out_channel, o_res.out_channel);
                check_field("out_station_id", want.out_station_id, o_res.out_station_id);
                check_field("out_signal_level", want.out_signal_level,
                            o_res.out_signal_level);
                check_field("fixed_count", want.fixed_count, o_res.fixed_count);
                check_field("portable_count", want.portable_count, o_res.portable_count);
                check_field("entry_count", want.entry_count, o_res.entry_count);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[station_match_count_table_top] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        localparam logic [ID_W-1:0] ID_TOP = '1;
        t_req        r;
        int unsigned sent;
        int unsigned kind;
        int unsigned len;
        int unsigned pick;
        bit          quiet;

        errors      = 0;
        cycle_count = 0;
        tbl_used    = 0;
        start       = 1'b0;
        i_req       = '0;
        i_rst_n     = 1'b0;
        for (int i = 0; i < int'(POOL_SIZE); i++) begin
            pool_chan[i] = CHAN_W'($urandom);
            pool_id[i]   = ID_W'({$urandom, $urandom});
        end

        add_row(mk_req(REQ_READ, 0, 0, 0, 0, 0), 1, mk_res(ST_RANGE, 0));
        add_row(mk_req(REQ_CLEAR, 0, 0, 0, 0, 0), 1, mk_res(ST_CLEARED, 0));
        add_row(mk_req(REQ_REPORT, 0, 0, 0, 0, 6'h3f), 1, mk_res(ST_INSERTED, 1));
        add_row(mk_req(REQ_REPORT, 7'h7f, ID_TOP, 1, 8'hff, 0), 1, mk_res(ST_INSERTED, 2));
        add_row(mk_req(REQ_REPORT, 0, 0, 1, 8'hff, 0), 1, mk_res(ST_UPDATED, 2));
        add_row(mk_req(REQ_REPORT, 7'h7f, ID_TOP, 0, 0, 6'h3f), 1, mk_res(ST_UPDATED, 2));
        add_row(mk_req(REQ_REPORT, 7'h7f, ID_TOP, 1, 8'h5a, 0), 1, mk_res(ST_UPDATED, 2));
        add_row(mk_req(REQ_REPORT, 0, ID_TOP, 0, 8'h11, 0), 0, '0);
        add_row(mk_req(REQ_REPORT, 7'h7f, 0, 1, 8'h22, 0), 0, '0);
        add_row(mk_req(REQ_REPORT, 0, 40'h80_0000_0001, 1, 8'h80, 0), 0, '0);
        add_row(mk_req(REQ_READ, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_req(REQ_SPARE, 7'h7f, ID_TOP, 1, 8'hff, 1), 0, '0);
        add_row(mk_req(REQ_READ, 0, 0, 0, 0, 3), 0, '0);
        add_row(mk_req(REQ_READ, 0, 0, 0, 0, 5), 1, mk_res(ST_RANGE, 5));
        add_row(mk_req(REQ_READ, 7'h7f, ID_TOP, 1, 8'hff, 6'h3f), 1, mk_res(ST_RANGE, 5));
        add_row(mk_req(REQ_SPARE, 0, 0, 0, 0, 4), 0, '0);
        add_row(mk_req(REQ_CLEAR, 7'h7f, ID_TOP, 1, 8'hff, 6'h3f), 1, mk_res(ST_CLEARED, 0));
        add_row(mk_req(REQ_READ, 0, 0, 0, 0, 0), 1, mk_res(ST_RANGE, 0));
        add_row(mk_req(REQ_REPORT, 7'h55, 40'haa_5555_aaaa, 0, 8'h33, 6'h2a), 1,
                mk_res(ST_INSERTED, 1));
        add_row(mk_req(REQ_READ, 0, 0, 0, 0, 0), 0, '0);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if ($urandom_range(0, 99) < 20) idle_gap($urandom_range(1, 100));
            send_item(directed_rows[i].req, directed_rows[i].given, directed_rows[i].res);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                len = $urandom_range(20, 60);
            end else if (kind < 8) begin
                len = $urandom_range(80, 110);
                if (tbl_used != 0) begin
                    quiet = (sent >= 300 && sent < 500);
                    if (!quiet && $urandom_range(0, 99) < 20) idle_gap($urandom_range(1, 100));
                    send_item(mk_req(REQ_CLEAR, CHAN_W'($urandom), 0, 1'($urandom), 0,
                                     IDX_W'($urandom)), 0, '0);
                    sent++;
                end
            end else begin
                len = $urandom_range(10, 30);
            end
            repeat (len) begin
                pick = $urandom_range(0, 99);
                if (kind < 5) begin
                    if (pick < 55)      r = make_report(0);
                    else if (pick < 70) r = make_report(1);
                    else if (pick < 95) r = make_read();
                    else                r = mk_req(REQ_CLEAR, 0, 0, 0, 0, 0);
                end else if (kind < 8) begin
                    if (pick < 75)      r = make_report(1);
                    else if (pick < 85) r = make_report(0);
                    else                r = make_read();
                end else begin
                    r = rand_req();
                end
                quiet = (sent >= 300 && sent < 500);
                if (!quiet && $urandom_range(0, 99) < 20) idle_gap($urandom_range(1, 100));
                send_item(r, 0, '0);
                sent++;
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0) begin
            $display("[station_match_count_table_top] OK");
        end else begin
            $display("[station_match_count_table_top] ERROR");
        end
        $finish;
    end
endmodule
